// ===== rtl/ukhc_pkg.sv =====
// ----------------------------------------------------------------------------
// ukhc_pkg: shared types and constants of the key hash counter
// table geometry, hash constants, status codes
// ----------------------------------------------------------------------------
package ukhc_pkg;

    localparam int KeyElements = 4;
    localparam int ElemW       = 16;
    localparam int KeyW        = KeyElements * ElemW;
    localparam int TableSlots  = 1024;
    localparam int SlotW       = $clog2(TableSlots);
    localparam int CountW      = 32;
    localparam int TotalW      = 11;

    localparam logic [63:0] HashMulInit = 64'd1000003;
    localparam logic [63:0] HashInit    = 64'h345678;
    localparam logic [63:0] HashMulStep = 64'd82520;
    localparam logic [63:0] HashOffset  = 64'd97531;

    localparam logic [TotalW-1:0] TotalMax = '1;
    localparam logic [CountW-1:0] CountMax = '1;

    typedef enum logic [1:0] {
        ST_NEW  = 2'd0,
        ST_HIT  = 2'd1,
        ST_FULL = 2'd2,
        ST_READ = 2'd3
    } t_status;

    // handshake between sequencer and multiply unit
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] p;
    } t_mul_rsp;

endpackage

// ===== rtl/unordered_key_hash_counter_unit.sv =====
// ----------------------------------------------------------------------------
// unordered_key_hash_counter_unit: multiset key counter, linear-probe table
// sorts a key, hashes it, finds or inserts it, or reads back one slot
// ----------------------------------------------------------------------------
// Usage: one input beat (mode, four elements, read slot) is taken when
// i_in_valid and o_in_ready are high; exactly one result beat follows on the
// o_out_* channel. The block handles one beat at a time: o_in_ready is low
// from acceptance until the result has been taken.
// A read passes the read, wait and finish states before its result. An add
// takes the sort (6 compare steps), four hash rounds through the shared 64-bit
// multiplier, a step to fold the hash, then a read, wait and compare per
// probed slot, bounded by the single-port table memory; a full table is found
// once all 1024 slots have been probed. The next beat can be taken in the
// cycle after the result is accepted. Reset clears the distinct total and
// starts a clearing pass over all 1024 slots that zeroes the key and count
// memories (a zero count marks a free slot); o_in_ready stays low until it
// ends. A stalled receiver holds the result stable and the block takes no
// new beat until it is accepted.
// ----------------------------------------------------------------------------
module unordered_key_hash_counter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [15:0] i_element_0,
    input  logic [15:0] i_element_1,
    input  logic [15:0] i_element_2,
    input  logic [15:0] i_element_3,
    input  logic [9:0]  i_read_slot,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [9:0]  o_slot,
    output logic        o_occupied,
    output logic [31:0] o_count,
    output logic [15:0] o_sorted_0,
    output logic [15:0] o_sorted_1,
    output logic [15:0] o_sorted_2,
    output logic [15:0] o_sorted_3,
    output logic [10:0] o_distinct_total
);
    localparam int SW = ukhc_pkg::SlotW;
    localparam int EW = ukhc_pkg::ElemW;
    localparam int NE = ukhc_pkg::KeyElements;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SORT, S_HX, S_HWAIT, S_HFIN, S_PRD, S_PWAIT, S_PCMP,
        S_RRD, S_RWAIT, S_RFIN, S_OUT
    } t_state;

    t_state r_state;
    logic [EW-1:0] r_k [NE];
    logic [2:0]  r_si;
    logic [1:0]  r_hi;
    logic [63:0] r_h, r_m;
    logic [SW-1:0] r_idx, r_home;
    logic [SW:0] r_probes;
    logic [ukhc_pkg::TotalW-1:0] r_total;
    ukhc_pkg::t_mul_req w_req;
    ukhc_pkg::t_mul_rsp w_rsp;

    // table memories, single port, registered read
    logic [ukhc_pkg::KeyW-1:0]   r_key_mem [ukhc_pkg::TableSlots];
    logic [ukhc_pkg::CountW-1:0] r_cnt_mem [ukhc_pkg::TableSlots];
    logic [ukhc_pkg::KeyW-1:0]   r_key_rd;
    logic [ukhc_pkg::CountW-1:0] r_cnt_rd;
    logic          w_we;
    logic [SW-1:0] w_addr;
    logic [ukhc_pkg::KeyW-1:0]   w_key_wr;
    logic [ukhc_pkg::CountW-1:0] w_cnt_wr;

    // output registers
    logic [1:0]  r_status;
    logic [SW-1:0] r_slot;
    logic        r_occ;
    logic [31:0] r_count;
    logic [EW-1:0] r_ok [NE];

    logic [ukhc_pkg::KeyW-1:0] w_key;
    logic [1:0] w_a;
    logic w_swap;
    logic w_same;
    logic w_free;

    always_comb begin
        for (int i = 0; i < NE; i++) w_key[i*EW +: EW] = r_k[i];
    end

    // bubble sort over fixed compare pairs: 0-1,1-2,2-3,0-1,1-2,0-1
    always_comb begin
        case (r_si)
            3'd1, 3'd4: w_a = 2'd1;
            3'd2:       w_a = 2'd2;
            default:    w_a = 2'd0;
        endcase
    end
    assign w_swap = r_k[w_a] > r_k[w_a + 2'd1];
    assign w_same = r_key_rd == w_key;
    // a zero count marks a free slot
    assign w_free = (r_cnt_rd == '0);

    assign w_req.start = (r_state == S_HX);
    assign w_req.a     = r_h ^ 64'(r_k[r_hi]);
    assign w_req.b     = r_m;

    ukhc_mul64 u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    // memory write on clearing pass, insert or count
    always_comb begin
        w_we     = 1'b0;
        w_addr   = (r_state == S_RRD || r_state == S_RWAIT) ? r_slot : r_idx;
        w_key_wr = w_key;
        w_cnt_wr = 32'd1;
        if (r_state == S_CLR) begin
            w_we     = 1'b1;
            w_key_wr = '0;
            w_cnt_wr = '0;
        end else if (r_state == S_PCMP) begin
            if (w_free) w_we = 1'b1;
            else if (w_same) begin
                w_we = 1'b1;
                w_cnt_wr = (r_cnt_rd == ukhc_pkg::CountMax) ? r_cnt_rd
                                                           : r_cnt_rd + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_key_mem[w_addr] <= w_key_wr;
            r_cnt_mem[w_addr] <= w_cnt_wr;
        end
        r_key_rd <= r_key_mem[w_addr];
        r_cnt_rd <= r_cnt_mem[w_addr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx   <= '0;
            r_total <= '0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == '1) r_state <= S_IDLE;
                end
                S_IDLE: if (i_in_valid) begin
                    r_k[0] <= i_element_0;
                    r_k[1] <= i_element_1;
                    r_k[2] <= i_element_2;
                    r_k[3] <= i_element_3;
                    r_slot <= i_read_slot;
                    r_si   <= '0;
                    r_hi   <= '0;
                    r_h    <= ukhc_pkg::HashInit;
                    r_m    <= ukhc_pkg::HashMulInit;
                    r_state <= i_mode ? S_RRD : S_SORT;
                end
                S_SORT: begin
                    if (w_swap) begin
                        r_k[w_a]        <= r_k[w_a + 2'd1];
                        r_k[w_a + 2'd1] <= r_k[w_a];
                    end
                    r_si <= r_si + 3'd1;
                    if (r_si == 3'd5) r_state <= S_HX;
                end
                S_HX: r_state <= S_HWAIT;
                S_HWAIT: if (w_rsp.done) begin
                    r_h <= w_rsp.p;
                    r_m <= r_m + ukhc_pkg::HashMulStep
                         + 64'({2'(NE - 1) - r_hi, 1'b0});
                    r_hi <= r_hi + 2'd1;
                    r_state <= (r_hi == 2'(NE - 1)) ? S_HFIN : S_HX;
                end
                S_HFIN: begin
                    r_home   <= SW'(r_h + ukhc_pkg::HashOffset);
                    r_idx    <= SW'(r_h + ukhc_pkg::HashOffset);
                    r_probes <= '0;
                    r_state  <= S_PRD;
                end
                S_PRD: r_state <= S_PWAIT;
                S_PWAIT: r_state <= S_PCMP;
                S_PCMP: begin
                    r_slot <= r_idx;
                    r_occ  <= 1'b1;
                    for (int i = 0; i < NE; i++) r_ok[i] <= r_k[i];
                    if (w_free) begin
                        if (r_total != ukhc_pkg::TotalMax) r_total <= r_total + 1'b1;
                        r_status <= ukhc_pkg::ST_NEW;
                        r_count  <= 32'd1;
                        r_state  <= S_OUT;
                    end else if (w_same) begin
                        r_status <= ukhc_pkg::ST_HIT;
                        r_count  <= w_cnt_wr;
                        r_state  <= S_OUT;
                    end else if (r_probes == (SW+1)'(ukhc_pkg::TableSlots - 1)) begin
                        r_status <= ukhc_pkg::ST_FULL;
                        r_slot   <= r_home;
                        r_occ    <= 1'b0;
                        r_count  <= '0;
                        r_state  <= S_OUT;
                    end else begin
                        r_idx    <= r_idx + 1'b1;
                        r_probes <= r_probes + 1'b1;
                        r_state  <= S_PRD;
                    end
                end
                S_RRD: r_state <= S_RWAIT;
                S_RWAIT: r_state <= S_RFIN;
                S_RFIN: begin
                    r_status <= ukhc_pkg::ST_READ;
                    r_occ    <= !w_free;
                    r_count  <= w_free ? '0 : r_cnt_rd;
                    for (int i = 0; i < NE; i++)
                        r_ok[i] <= w_free ? '0 : r_key_rd[i*EW +: EW];
                    r_state <= S_OUT;
                end
                S_OUT: if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = (r_state == S_OUT);
    assign o_status         = r_status;
    assign o_slot           = r_slot;
    assign o_occupied       = r_occ;
    assign o_count          = r_count;
    assign o_sorted_0       = r_ok[0];
    assign o_sorted_1       = r_ok[1];
    assign o_sorted_2       = r_ok[2];
    assign o_sorted_3       = r_ok[3];
    assign o_distinct_total = r_total;
endmodule

// ===== rtl/ukhc_mul64.sv =====
// ----------------------------------------------------------------------------
// ukhc_mul64: shared wrapping 64-bit multiplier
// low 64 bits of a*b from three 32x32 partial products, one per cycle
// ----------------------------------------------------------------------------
module ukhc_mul64 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ukhc_pkg::t_mul_req i_req,
    output ukhc_pkg::t_mul_rsp o_rsp
);
    logic [63:0] r_a, r_b, r_acc;
    logic [2:0]  r_step;
    logic        r_busy, r_done;
    logic [31:0] w_x, w_y;
    logic [63:0] r_pp;
    logic        r_ppv;
    logic [1:0]  r_ppi;

    // operand select per step: lo*lo, lo*hi, hi*lo (hi*hi drops out)
    always_comb begin
        w_x = r_a[31:0];
        w_y = r_b[31:0];
        case (r_step)
            3'd1: w_y = r_b[63:32];
            3'd2: w_x = r_a[63:32];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ppv  <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            r_ppv  <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_step < 3'd3) begin
                    r_pp   <= 64'(w_x) * 64'(w_y);
                    r_ppv  <= 1'b1;
                    r_ppi  <= r_step[1:0];
                    r_step <= r_step + 3'd1;
                end
                if (r_ppv) begin
                    if (r_ppi == 2'd0) r_acc <= r_acc + r_pp;
                    else r_acc <= r_acc + {r_pp[31:0], 32'd0};
                    if (r_ppi == 2'd2) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;
endmodule

// ===== rtl/ukhc_checker.sv =====
// ----------------------------------------------------------------------------
// ukhc_checker: port-level checks of the key hash counter
// one result per beat, sorted output, distinct total behavior
// ----------------------------------------------------------------------------
module ukhc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic        o_occupied,
    input logic [15:0] o_sorted_0,
    input logic [15:0] o_sorted_1,
    input logic [15:0] o_sorted_2,
    input logic [15:0] o_sorted_3,
    input logic [10:0] o_distinct_total
);
    // never ready for input while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("ready while result pending");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("result dropped");

    // shown keys are ascending
    a_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_occupied |->
        o_sorted_0 <= o_sorted_1 && o_sorted_1 <= o_sorted_2 &&
        o_sorted_2 <= o_sorted_3) else $error("key not sorted");

    // distinct total never decreases
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> o_distinct_total >= $past(o_distinct_total))
        else $error("distinct total fell");
endmodule

bind unordered_key_hash_counter_unit ukhc_checker u_ukhc_checker (.*);
